FILE: src/ita_pkg.sv
// Shared types, constants and helpers for the integer-to-ASCII formatter.
package ita_pkg;

    localparam int unsigned VALUE_W  = 64;
    localparam int unsigned OP_W     = 2;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned COUNT_W  = 32;
    localparam int unsigned DEC_W    = 32;
    localparam int unsigned NIBBLES  = VALUE_W / 4;
    localparam int unsigned BCD_DIGS = 10;
    localparam int unsigned BCD_W    = BCD_DIGS * 4;
    localparam int unsigned REM_W    = $clog2(NIBBLES + 1);
    localparam int unsigned BIT_W    = $clog2(DEC_W);
    localparam int unsigned OUT_W    = COUNT_W + CHAR_W;

    localparam logic [OP_W-1:0] OP_SDEC = 2'd0;
    localparam logic [OP_W-1:0] OP_UDEC = 2'd1;
    localparam logic [OP_W-1:0] OP_HEX  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;

    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_LOW_A = 8'h61;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
    } t_conv_req;

    typedef struct packed {
        logic [VALUE_W-1:0] digits;
        logic               neg;
    } t_conv_res;

    // Lowercase hex character for one digit.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        logic [CHAR_W-1:0] c;
        if (d < 4'd10) begin
            c = ASCII_ZERO + {4'd0, d};
        end else begin
            c = ASCII_LOW_A + {4'd0, d - 4'd10};
        end
        return c;
    endfunction

endpackage

FILE: src/ita_dabble.sv
// Bit-serial binary to BCD converter (shift and add three), hex passes straight through.
module ita_dabble (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  ita_pkg::t_conv_req  i_req,
    output logic                o_busy,
    output logic                o_done,
    output ita_pkg::t_conv_res  o_res
);
    import ita_pkg::*;

    typedef enum logic {D_IDLE, D_RUN} t_state;

    t_state             r_state;
    logic               r_done;
    logic               r_neg;
    logic [VALUE_W-1:0] r_dig;
    logic [DEC_W-1:0]   r_bin;
    logic [BIT_W-1:0]   r_bit;
    logic [BCD_W-1:0]   n_adj;
    logic [DEC_W-1:0]   n_mag;
    logic [DEC_W-1:0]   n_low;

    assign n_low = i_req.value[DEC_W-1:0];
    assign n_mag = (i_req.op == OP_SDEC && n_low[DEC_W-1]) ? (~n_low + 1'b1) : n_low;

    // Add three to every BCD digit of five or more before the next shift.
    always_comb begin
        for (int i = 0; i < BCD_DIGS; i++) begin
            if (r_dig[i*4 +: 4] >= 4'd5) begin
                n_adj[i*4 +: 4] = r_dig[i*4 +: 4] + 4'd3;
            end else begin
                n_adj[i*4 +: 4] = r_dig[i*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        if (i_req.op == OP_HEX) begin
                            r_dig  <= i_req.value;
                            r_neg  <= 1'b0;
                            r_done <= 1'b1;
                        end else if (i_req.op == OP_SDEC || i_req.op == OP_UDEC) begin
                            r_dig   <= '0;
                            r_bin   <= n_mag;
                            r_neg   <= (i_req.op == OP_SDEC) && n_low[DEC_W-1];
                            r_bit   <= BIT_W'(DEC_W - 1);
                            r_state <= D_RUN;
                        end
                    end
                end
                D_RUN: begin
                    r_dig <= {{(VALUE_W-BCD_W){1'b0}}, n_adj[BCD_W-2:0], r_bin[DEC_W-1]};
                    r_bin <= {r_bin[DEC_W-2:0], 1'b0};
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_busy       = (r_state == D_RUN) || r_done;
    assign o_done       = r_done;
    assign o_res.digits = r_dig;
    assign o_res.neg    = r_neg;

endmodule

FILE: src/ita_emit.sv
// Character emitter: drops leading zero digits, then sends sign and digits one per output transfer.
module ita_emit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  ita_pkg::t_conv_res          i_res,
    output logic                        o_idle,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [ita_pkg::OUT_W-1:0]   o_m_tdata,
    output logic                        o_m_tlast
);
    import ita_pkg::*;

    typedef enum logic [1:0] {E_IDLE, E_SKIP, E_SIGN, E_DIGIT} t_state;

    t_state             r_state;
    logic [VALUE_W-1:0] r_dig;
    logic [REM_W-1:0]   r_rem;
    logic               r_neg;
    logic               r_valid;
    logic               r_last;
    logic [CHAR_W-1:0]  r_char;
    logic [COUNT_W-1:0] r_count;
    logic               n_free;

    // The output register can take a new character when empty or being drained.
    assign n_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (r_valid && i_m_tready) begin
                r_valid <= 1'b0;
            end
            unique case (r_state)
                E_IDLE: begin
                    if (i_load) begin
                        r_dig   <= i_res.digits;
                        r_neg   <= i_res.neg;
                        r_rem   <= REM_W'(NIBBLES);
                        r_state <= E_SKIP;
                    end
                end
                E_SKIP: begin
                    if (r_dig[VALUE_W-1 -: 4] == 4'd0 && r_rem > REM_W'(1)) begin
                        r_dig <= {r_dig[VALUE_W-5:0], 4'd0};
                        r_rem <= r_rem - 1'b1;
                    end else begin
                        r_state <= r_neg ? E_SIGN : E_DIGIT;
                    end
                end
                E_SIGN: begin
                    if (n_free) begin
                        r_char  <= ASCII_MINUS;
                        r_last  <= 1'b0;
                        r_valid <= 1'b1;
                        r_count <= r_count + 1'b1;
                        r_state <= E_DIGIT;
                    end
                end
                E_DIGIT: begin
                    if (n_free) begin
                        r_char  <= digit_char(r_dig[VALUE_W-1 -: 4]);
                        r_last  <= (r_rem == REM_W'(1));
                        r_valid <= 1'b1;
                        r_count <= r_count + 1'b1;
                        r_dig   <= {r_dig[VALUE_W-5:0], 4'd0};
                        r_rem   <= r_rem - 1'b1;
                        if (r_rem == REM_W'(1)) begin
                            r_state <= E_IDLE;
                        end
                    end
                end
                default: r_state <= E_IDLE;
            endcase
        end
    end

    assign o_idle     = (r_state == E_IDLE);
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_count, r_char};
    assign o_m_tlast  = r_last;

endmodule

FILE: src/integer_to_ascii_formatter.sv
// Integer-to-ASCII formatter: one number in, its characters out most significant first.
// A request carries the operation in tuser (0 signed decimal, 1 unsigned decimal, both on the
// low 32 bits of tdata, 2 lowercase hex of all 64 bits, 3 ignored) and is taken only when the
// previous number has been fully handed to the output register. Decimal requests pass through
// the bit-serial shift-and-add-three converter, one input bit per cycle; hex skips it. The
// emitter then drops one leading zero digit per cycle (up to 15 of them), chooses between
// sign and digit, and sends one character per cycle while the output register is free, a
// minus sign first for negative signed values. A character that waits on the output delays
// the next request. Each result carries the character and a wrapping 32-bit count of
// characters sent since reset.
module integer_to_ascii_formatter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [ita_pkg::VALUE_W-1:0]     i_s_tdata,   // [63:0] value
    input  logic [ita_pkg::OP_W-1:0]        i_s_tuser,   // [1:0] operation
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [ita_pkg::OUT_W-1:0]       o_m_tdata,   // [7:0] character, [39:8] total_count
    output logic                            o_m_tlast
);
    import ita_pkg::*;

    t_conv_req n_req;
    t_conv_res n_res;
    logic      n_start;
    logic      n_busy;
    logic      n_done;
    logic      n_idle;

    assign o_s_tready = !n_busy && n_idle;
    assign n_start    = i_s_tvalid && o_s_tready;
    assign n_req.op    = i_s_tuser;
    assign n_req.value = i_s_tdata;

    ita_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_start),
        .i_req   (n_req),
        .o_busy  (n_busy),
        .o_done  (n_done),
        .o_res   (n_res)
    );

    ita_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (n_done),
        .i_res      (n_res),
        .o_idle     (n_idle),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

FILE: src/ita_chk.sv
// Port-level checks for the integer-to-ASCII formatter, bound to the top level.
module ita_chk (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        o_s_tready,
    input  logic [ita_pkg::OP_W-1:0]    i_s_tuser,
    input  logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [ita_pkg::OUT_W-1:0]   o_m_tdata,
    input  logic                        o_m_tlast
);
    import ita_pkg::*;

    // A stalled result holds its character and count.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast)))
        else $error("stalled result changed");

    // A number that prints keeps the input closed in the following cycle.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser != OP_NONE) |=> !o_s_tready)
        else $error("request taken while a number is in progress");

    // While a character that is not the last waits, the number is unfinished.
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> !o_s_tready)
        else $error("input open before the last character");

    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind integer_to_ascii_formatter ita_chk u_ita_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
